### hdl/irs_pkg.sv
// Shared types and codes of the interface route selector.
package irs_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int INDEX_W     = 3;
  localparam int ADDR_W      = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_GATEWAY = 2'd1;
  localparam logic [1:0] REASON_SOURCE  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  entry_address;
    logic [ADDR_W-1:0]  entry_netmask;
    logic [ADDR_W-1:0]  entry_gateway;
    logic               entry_up;
    logic               entry_link_up;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  destination_address;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] selected_index;
    logic [1:0]         selection_reason;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] netmask;
    logic [ADDR_W-1:0] gateway;
    logic              up;
    logic              link_up;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [INDEX_W-1:0] idx;
    entry_t             entry;
  } tbl_wr_t;

endpackage

### hdl/irs_req_if.sv
// Request channel of the interface route selector.
interface irs_req_if;
  logic          valid;
  logic          ready;
  irs_pkg::req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hdl/irs_rsp_if.sv
// Response channel of the interface route selector.
interface irs_rsp_if;
  logic          valid;
  logic          ready;
  irs_pkg::rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hdl/irs_table.sv
// Interface table memory with per-slot valid bits and registered read.
module irs_table #(
  parameter int ENTRIES = irs_pkg::ENTRIES_DEF,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  irs_pkg::tbl_wr_t wr,
  input  logic [AW-1:0]    raddr,
  output irs_pkg::entry_t  rdata
);

  localparam logic [6:0] ENTRIES_V = 7'(ENTRIES);

  irs_pkg::entry_t        mem [ENTRIES];
  logic [ENTRIES-1:0]     vld;
  irs_pkg::entry_t        rd_mem;
  logic                   rd_vld;
  logic                   wr_ok;

  assign wr_ok = wr.we && (7'(wr.idx) < ENTRIES_V);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[AW'(wr.idx)] <= wr.entry;
    end
    rd_mem <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld[AW'(wr.idx)] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_mem : '0;

endmodule

### hdl/irs_scan.sv
// Request sequencer: table writes and the three lookup scans.
module irs_scan #(
  parameter int ENTRIES = irs_pkg::ENTRIES_DEF,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  irs_req_if.sink          req,
  irs_rsp_if.source        rsp,
  output irs_pkg::tbl_wr_t wr,
  output logic [AW-1:0]    raddr,
  input  irs_pkg::entry_t  rdata
);

  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_GW   = 3'd2;
  localparam logic [2:0] S_SRC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                    state;
  logic [CW-1:0]                 cnt;
  logic                          dv;
  logic [AW-1:0]                 didx;
  logic [irs_pkg::ADDR_W-1:0]    src;
  logic [irs_pkg::ADDR_W-1:0]    dst;
  logic [irs_pkg::ADDR_W-1:0]    key;
  logic                          best_ok;
  logic [irs_pkg::ADDR_W-1:0]    best_mask;
  logic [irs_pkg::ADDR_W-1:0]    best_gw;
  logic                          found;
  logic [irs_pkg::INDEX_W-1:0]   sel;
  logic [1:0]                    reason;

  logic scanning;
  logic issue;
  logic scan_end;
  logic active;
  logic win_hit;
  logic addr_hit;

  assign req.ready = (state == S_IDLE);

  assign wr.we    = req.valid && req.ready && (req.data.op == irs_pkg::OP_WRITE);
  assign wr.idx   = req.data.entry_index;
  assign wr.entry = '{address: req.data.entry_address,
                      netmask: req.data.entry_netmask,
                      gateway: req.data.entry_gateway,
                      up:      req.data.entry_up,
                      link_up: req.data.entry_link_up};

  assign scanning = (state == S_WIN) || (state == S_GW) || (state == S_SRC);
  assign issue    = scanning && (cnt != CW'(ENTRIES));
  assign scan_end = (cnt == CW'(ENTRIES)) && !dv;
  assign raddr    = cnt[AW-1:0];

  assign active   = rdata.up && rdata.link_up;
  assign win_hit  = active && ((dst & rdata.netmask) == (rdata.address & rdata.netmask))
                    && (!best_ok || (rdata.netmask > best_mask));
  assign addr_hit = active && (rdata.address != '0) && (rdata.address == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      dv        <= 1'b0;
      best_ok   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      dv   <= issue;
      didx <= cnt[AW-1:0];
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && (req.data.op == irs_pkg::OP_LOOKUP)) begin
            src     <= req.data.source_address;
            dst     <= req.data.destination_address;
            key     <= req.data.source_address;
            best_ok <= 1'b0;
            found   <= 1'b0;
            sel     <= '0;
            reason  <= irs_pkg::REASON_NONE;
            cnt     <= '0;
            if (req.data.destination_address != '0) begin
              state <= S_WIN;
            end else if (req.data.source_address != '0) begin
              state <= S_SRC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WIN: begin
          if (dv && win_hit) begin
            best_ok   <= 1'b1;
            best_mask <= rdata.netmask;
            best_gw   <= rdata.gateway;
          end
          if (scan_end) begin
            cnt <= '0;
            if (best_ok) begin
              key   <= best_gw;
              state <= S_GW;
            end else if (src != '0) begin
              key   <= src;
              state <= S_SRC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_GW: begin
          if (dv && addr_hit) begin
            found  <= 1'b1;
            sel    <= irs_pkg::INDEX_W'(didx);
            reason <= irs_pkg::REASON_GATEWAY;
            cnt    <= '0;
            dv     <= 1'b0;
            state  <= S_DONE;
          end else if (scan_end) begin
            cnt <= '0;
            if (src != '0) begin
              key   <= src;
              state <= S_SRC;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SRC: begin
          if (dv && addr_hit) begin
            found  <= 1'b1;
            sel    <= irs_pkg::INDEX_W'(didx);
            reason <= irs_pkg::REASON_SOURCE;
            cnt    <= '0;
            dv     <= 1'b0;
            state  <= S_DONE;
          end else if (scan_end) begin
            cnt   <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.data  <= '{found: found, selected_index: sel, selection_reason: reason};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/interface_route_selector_top.sv
// Top level of the interface route selector.
// A write request gives no response; the next request follows at once.
// A lookup is bound by the single read port of the table, which it reads
// one slot per cycle in up to three scans.
// One request is in work at a time; a finished response waits in an output register.
// Reset clears the slot valid bits, so every slot reads as absent.
module interface_route_selector_top #(
  parameter int ENTRIES = irs_pkg::ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  irs_req_if.sink   req,
  irs_rsp_if.source rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  irs_pkg::tbl_wr_t wr;
  logic [AW-1:0]    raddr;
  irs_pkg::entry_t  rdata;

  irs_table #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .raddr(raddr),
    .rdata(rdata)
  );

  irs_scan #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .wr   (wr),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

### hdl/irs_checker.sv
// Port-level assertions of the interface route selector and their binding.
module irs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          req_op,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_found,
  input logic [irs_pkg::INDEX_W-1:0]   rsp_index,
  input logic [1:0]                    rsp_reason
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_found, rsp_index, rsp_reason}))
    else $error("response dropped or changed while stalled");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_op == irs_pkg::OP_LOOKUP) |=> !req_ready)
    else $error("request taken while a lookup is in work");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> (rsp_index == '0) && (rsp_reason == irs_pkg::REASON_NONE))
    else $error("miss response carries index or reason");

  a_hit_reason: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |->
      (rsp_reason == irs_pkg::REASON_GATEWAY) || (rsp_reason == irs_pkg::REASON_SOURCE))
    else $error("hit response without a reason");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("block not idle after reset");

endmodule

bind interface_route_selector_top irs_checker u_irs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_op    (req.data.op),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_found (rsp.data.found),
  .rsp_index (rsp.data.selected_index),
  .rsp_reason(rsp.data.selection_reason)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the interface route selector: directed and random requests against a local table.
module tb_top;

  localparam int ENTRIES      = irs_pkg::ENTRIES_DEF;
  localparam int ADDR_W       = irs_pkg::ADDR_W;
  localparam int POOL_SIZE    = 10;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  logic clk    = 1'b0;
  logic rst    = 1'b1;
  logic idling = 1'b1;

  int error_count  = 0;
  int quiet_cycles = 0;
  int ready_hold   = 0;

  irs_pkg::rsp_t pending_routes[$];

  logic [ADDR_W-1:0] slot_address[ENTRIES];
  logic [ADDR_W-1:0] slot_netmask[ENTRIES];
  logic [ADDR_W-1:0] slot_gateway[ENTRIES];
  logic              slot_up[ENTRIES];
  logic              slot_link[ENTRIES];
  logic [ADDR_W-1:0] host_pool[POOL_SIZE];

  irs_req_if req_ch();
  irs_rsp_if rsp_ch();

  interface_route_selector_top #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #10 clk = ~clk;

  function automatic int first_active_with(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_up[i] && slot_link[i] && slot_address[i] != '0 && slot_address[i] == addr) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic irs_pkg::rsp_t predict_route(irs_pkg::req_t r);
    int            best;
    int            pick;
    irs_pkg::rsp_t res;
    best = -1;
    pick = -1;
    res  = '0;
    if (r.destination_address != '0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_up[i] && slot_link[i] &&
            (r.destination_address & slot_netmask[i]) == (slot_address[i] & slot_netmask[i]) &&
            (best < 0 || slot_netmask[i] > slot_netmask[best])) begin
          best = i;
        end
      end
    end
    if (best >= 0) begin
      pick = first_active_with(slot_gateway[best]);
      if (pick >= 0) res.selection_reason = irs_pkg::REASON_GATEWAY;
    end
    if (pick < 0 && r.source_address != '0) begin
      pick = first_active_with(r.source_address);
      if (pick >= 0) res.selection_reason = irs_pkg::REASON_SOURCE;
    end
    if (pick >= 0) begin
      res.found          = 1'b1;
      res.selected_index = irs_pkg::INDEX_W'(pick);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  function automatic logic [ADDR_W-1:0] pool_address();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      default: return host_pool[$urandom_range(0, POOL_SIZE-1)];
    endcase
  endfunction

  task automatic send_request(irs_pkg::req_t r);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (r.op == irs_pkg::OP_LOOKUP) begin
      pending_routes.push_back(predict_route(r));
    end else begin
      slot_address[r.entry_index] = r.entry_address;
      slot_netmask[r.entry_index] = r.entry_netmask;
      slot_gateway[r.entry_index] = r.entry_gateway;
      slot_up[r.entry_index]      = r.entry_up;
      slot_link[r.entry_index]    = r.entry_link_up;
    end
  endtask

  task automatic write_slot(int idx, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] mask,
                            logic [ADDR_W-1:0] gw, logic up, logic link);
    irs_pkg::req_t r;
    r.op                  = irs_pkg::OP_WRITE;
    r.entry_index         = irs_pkg::INDEX_W'(idx);
    r.entry_address       = addr;
    r.entry_netmask       = mask;
    r.entry_gateway       = gw;
    r.entry_up            = up;
    r.entry_link_up       = link;
    r.source_address      = $urandom;
    r.destination_address = $urandom;
    send_request(r);
  endtask

  task automatic lookup_route(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
    irs_pkg::req_t r;
    r.op                  = irs_pkg::OP_LOOKUP;
    r.entry_index         = irs_pkg::INDEX_W'($urandom_range(0, 7));
    r.entry_address       = $urandom;
    r.entry_netmask       = $urandom;
    r.entry_gateway       = $urandom;
    r.entry_up            = 1'($urandom_range(0, 1));
    r.entry_link_up       = 1'($urandom_range(0, 1));
    r.source_address      = src;
    r.destination_address = dst;
    send_request(r);
  endtask

  task automatic random_write(int idx);
    write_slot(idx, pool_address(), prefix_mask($urandom_range(0, 32)), pool_address(),
               $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
  endtask

  task automatic run_route_rounds(int count);
    int                sent;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] dst;
    sent = 0;
    while (sent < count) begin
      base = $urandom;
      for (int k = 0; k < POOL_SIZE; k++) begin
        host_pool[k] = {base[31:18], 2'($urandom_range(0, 3)), 16'($urandom)};
      end
      for (int s = 0; s < ENTRIES; s++) begin
        random_write(s);
        sent++;
      end
      repeat (20) begin
        if ($urandom_range(0, 3) == 0) begin
          random_write($urandom_range(0, ENTRIES-1));
        end else begin
          dst = pool_address() ^ ($urandom & ~prefix_mask($urandom_range(8, 32)));
          if ($urandom_range(0, 9) == 0) dst = '0;
          lookup_route(pool_address(), dst);
        end
        sent++;
      end
    end
  endtask

  task automatic test_empty_table();
    lookup_route(32'hC0A8_0101, 32'h0A00_0001);
    lookup_route(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_routes();
    write_slot(0, 32'h0A00_0001, 32'hFF00_0000, 32'hC0A8_0101, 1'b1, 1'b1);
    write_slot(1, 32'hC0A8_0101, 32'hFFFF_FF00, 32'h0000_0000, 1'b1, 1'b1);
    write_slot(2, 32'h0A01_0001, 32'hFFFF_0000, 32'h0A00_0001, 1'b1, 1'b1);
    write_slot(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b1);
    write_slot(4, 32'h0A00_0001, 32'hFF00_0000, 32'hC0A8_0101, 1'b1, 1'b0);
    write_slot(5, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0101, 1'b1, 1'b1);
    write_slot(7, 32'hC0A8_0101, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    lookup_route(32'h0000_0000, 32'h0A02_0304);
    lookup_route(32'h0000_0000, 32'h0A01_0203);
    lookup_route(32'hC0A8_0101, 32'hFFFF_FFFF);
    lookup_route(32'h0A00_0001, 32'h0000_0000);
    lookup_route(32'h0000_0000, 32'h0000_0000);
    lookup_route(32'h0000_0000, 32'h0B00_0000);
    lookup_route(32'h0000_0000, 32'hC0A8_01FE);
    lookup_route(32'hFFFF_FFFF, 32'hC0A8_01FE);
    write_slot(6, 32'h0A00_0099, 32'hFF00_0000, 32'h0A01_0001, 1'b1, 1'b1);
    lookup_route(32'h0000_0000, 32'h0A00_00AA);
    write_slot(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
    lookup_route(32'h0000_0000, 32'h0A00_00AA);
  endtask

  task automatic test_random_routes();
    run_route_rounds(1200);
  endtask

  task automatic test_random_noise();
    irs_pkg::req_t r;
    repeat (300) begin
      r.op                  = 1'($urandom_range(0, 1));
      r.entry_index         = irs_pkg::INDEX_W'($urandom_range(0, 7));
      r.entry_address       = $urandom;
      r.entry_netmask       = $urandom;
      r.entry_gateway       = $urandom;
      r.entry_up            = 1'($urandom_range(0, 1));
      r.entry_link_up       = 1'($urandom_range(0, 1));
      r.source_address      = $urandom;
      r.destination_address = $urandom;
      send_request(r);
    end
  endtask

  task automatic test_steady_flow();
    idling <= 1'b0;
    run_route_rounds(250);
  endtask

  always @(posedge clk) begin : response_check
    irs_pkg::rsp_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (pending_routes.size() == 0) begin
        $error("response with no lookup pending");
        error_count++;
      end else begin
        want = pending_routes.pop_front();
        if (rsp_ch.data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, rsp_ch.data.found);
          error_count++;
        end
        if (rsp_ch.data.selected_index !== want.selected_index) begin
          $error("selected_index: expected %0d, actual %0d",
                 want.selected_index, rsp_ch.data.selected_index);
          error_count++;
        end
        if (rsp_ch.data.selection_reason !== want.selection_reason) begin
          $error("selection_reason: expected %0d, actual %0d",
                 want.selection_reason, rsp_ch.data.selection_reason);
          error_count++;
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
      rsp_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 8);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_address[i] = '0;
      slot_netmask[i] = '0;
      slot_gateway[i] = '0;
      slot_up[i]      = 1'b0;
      slot_link[i]    = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_routes();
    test_random_routes();
    test_random_noise();
    test_steady_flow();
    req_ch.valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
